### hdl/arc_run_fan_edge_detector_top_defines.svh
// assertion macros for the arc run fan edge detector
// expects clock and reset in the scope where a macro is used
`ifndef ARC_RUN_FAN_EDGE_DETECTOR_TOP_DEFINES_SVH
`define ARC_RUN_FAN_EDGE_DETECTOR_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define ARCFAN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define ARCFAN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/arcfan_pkg.sv
// types, register indexes and helpers of the arc run fan edge detector
// no dependencies
`default_nettype none

package arcfan_pkg;

   localparam int PIXEL_W = 8;
   localparam int ANGLE_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;

   // register indexes of the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_PIXEL_THRESHOLD = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RIGHT_LIMIT = 1'b1;

   // register reset values
   localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd33;
   localparam logic [ANGLE_W-1:0] RIGHT_LIMIT_RESET = 16'd0;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;
   // difference of two angles
   typedef logic signed [ANGLE_W:0] span_type;

   // one entry of the window memory
   typedef struct packed {
      logic bright;
      angle_type angle;
   } win_entry_type;

   // sample moving from the window write stage to the run stage
   typedef struct packed {
      logic bright;
      angle_type angle;
      logic sub_oldest;
      logic eval;
      logic arc_done;
      logic frame_done;
   } run_item_type;

   // widest run of a finished arc, moving to the frame stage
   typedef struct packed {
      angle_type left;
      angle_type right;
      span_type span;
      logic frame_done;
   } arc_item_type;

   // signed span right minus left, exact
   function automatic span_type span_of(angle_type left, angle_type right);
      span_type l_ext;
      span_type r_ext;
      l_ext = {left[ANGLE_W-1], left};
      r_ext = {right[ANGLE_W-1], right};
      return r_ext - l_ext;
   endfunction

endpackage

`default_nettype wire

### hdl/arc_run_fan_edge_detector_top.sv
// Arc run fan edge detector. Accepts one sample per clock; a frame result moves through the s2,
// s3 and output registers after its frame_end sample is accepted. The window of the last WINDOW
// samples lives in a memory with one write and one registered read per cycle, so the
// sustained rate is one sample per cycle; the input stalls only while a frame result waits
// unaccepted in the output register and the next frame end has reached the last stage.
// depends on arcfan_pkg and arc_run_fan_edge_detector_top_defines.svh
`default_nettype none
`include "arc_run_fan_edge_detector_top_defines.svh"

module arc_run_fan_edge_detector_top
   import arcfan_pkg::*;
#(
   parameter int WINDOW = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // sample channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [23:0]           req_tdata,   // pixel [7:0], angle [23:8]
   input  wire logic                  req_tuser,   // arc_end
   input  wire logic                  req_tlast,   // frame_end
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,   // left_angle [15:0], right_angle [31:16]
   output logic                       rsp_tuser,   // frame_empty
   // csr write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW = $clog2(WINDOW + 1);
   localparam logic [AW-1:0] LAST_POS = AW'(WINDOW - 1);
   localparam logic [CW-1:0] FILL_FULL = CW'(WINDOW);
   localparam logic [CW-1:0] FILL_EVAL = CW'(WINDOW - 1);
   localparam logic [CW:0] HALF_CMP = (CW + 1)'(WINDOW);

   // csr registers
   pixel_type thr_ff;
   angle_type rlim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THRESHOLD_RESET;
         rlim_ff <= RIGHT_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PIXEL_THRESHOLD: thr_ff <= csr_wdata[PIXEL_W-1:0];
            CSR_RIGHT_LIMIT:     rlim_ff <= csr_wdata[ANGLE_W-1:0];
            default:             ;
         endcase
      end
   end

   // pipeline control
   logic adv;
   logic req_acc;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   run_item_type s2_ff, s2_in;
   arc_item_type s3_ff, s3_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic rsp_empty_ff, rsp_empty_in;

   // the whole pipeline holds only when a frame result cannot enter the output register
   assign adv = !(s3_valid_ff && s3_ff.frame_done && rsp_valid_ff && !rsp_tready);
   assign req_tready = adv;
   assign req_acc = req_tvalid && adv;

   // window write stage
   pixel_type req_pixel;
   angle_type req_angle;
   logic req_end;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] fill_ff, fill_in;
   logic fill_full;

   assign req_pixel = req_tdata[PIXEL_W-1:0];
   assign req_angle = req_tdata[PIXEL_W+ANGLE_W-1:PIXEL_W];
   assign req_end = req_tuser || req_tlast;
   assign rd_addr = (wp_ff == LAST_POS) ? '0 : wp_ff + 1'b1;
   assign fill_full = (fill_ff == FILL_FULL);

   always_comb begin
      wp_in = wp_ff;
      fill_in = fill_ff;
      s2_in = s2_ff;
      s2_valid_in = s2_valid_ff;
      if (adv) begin
         s2_valid_in = req_acc;
         s2_in.bright = (req_pixel >= thr_ff);
         s2_in.angle = req_angle;
         s2_in.sub_oldest = fill_full;
         s2_in.eval = (fill_ff >= FILL_EVAL);
         s2_in.arc_done = req_end;
         s2_in.frame_done = req_tlast;
      end
      if (req_acc) begin
         wp_in = req_end ? '0 : rd_addr;
         fill_in = req_end ? '0 : (fill_full ? fill_ff : fill_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         fill_ff <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in;
         fill_ff <= fill_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
   end

   // window memory: write the new sample, read the entry after it (oldest after the write)
   win_entry_type win_mem [WINDOW];
   win_entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         win_mem[wp_ff] <= '{bright: (req_pixel >= thr_ff), angle: req_angle};
         rd_ff <= win_mem[rd_addr];
      end
   end

   // run stage: count update, run open and close, widest run of the arc
   logic [CW-1:0] cnt_ff, cnt_in;
   logic in_run_ff, in_run_in;
   angle_type run_start_ff, run_start_in;
   logic best_valid_ff, best_valid_in;
   angle_type best_left_ff, best_left_in;
   angle_type best_right_ff, best_right_in;
   span_type best_span_ff, best_span_in;
   logic prev_bright_ff;

   logic [CW-1:0] cnt_new;
   logic [CW:0] cnt_twice;
   logic open_now, close_now, close_take;
   span_type close_span, fin_span;
   logic mid_valid, mid_in_run;
   angle_type mid_start, mid_left, mid_right, fin_left;
   span_type mid_span;
   logic fin_take;

   always_comb begin
      // bright count over the window
      cnt_new = cnt_ff - ((s2_ff.sub_oldest && prev_bright_ff) ? CW'(1) : CW'(0))
                + (s2_ff.bright ? CW'(1) : CW'(0));
      cnt_twice = {cnt_new, 1'b0};
      open_now = s2_ff.eval && !in_run_ff && (cnt_twice >= HALF_CMP);
      close_now = s2_ff.eval && in_run_ff && (cnt_twice <= HALF_CMP);

      // run closed by the window
      close_span = span_of(run_start_ff, s2_ff.angle);
      close_take = close_now && (!best_valid_ff || (close_span > best_span_ff));
      mid_valid = best_valid_ff || close_now;
      mid_left = close_take ? run_start_ff : best_left_ff;
      mid_right = close_take ? s2_ff.angle : best_right_ff;
      mid_span = close_take ? close_span : best_span_ff;
      mid_in_run = open_now || (in_run_ff && !close_now);
      mid_start = open_now ? rd_ff.angle : run_start_ff;

      // arc end: an open run closes at the right limit, else the empty run
      if (open_now) begin
         fin_span = span_of(rd_ff.angle, rlim_ff);
      end else if (mid_in_run) begin
         fin_span = span_of(run_start_ff, rlim_ff);
      end else begin
         fin_span = '0;
      end
      fin_left = mid_in_run ? mid_start : rlim_ff;
      fin_take = !mid_valid || (fin_span > mid_span);

      cnt_in = cnt_ff;
      in_run_in = in_run_ff;
      run_start_in = run_start_ff;
      best_valid_in = best_valid_ff;
      best_left_in = best_left_ff;
      best_right_in = best_right_ff;
      best_span_in = best_span_ff;
      s3_in = s3_ff;
      s3_valid_in = s3_valid_ff;
      if (adv) begin
         s3_valid_in = s2_valid_ff && s2_ff.arc_done;
         s3_in.left = fin_take ? fin_left : mid_left;
         s3_in.right = fin_take ? rlim_ff : mid_right;
         s3_in.span = fin_take ? fin_span : mid_span;
         s3_in.frame_done = s2_ff.frame_done;
         if (s2_valid_ff) begin
            if (s2_ff.arc_done) begin
               cnt_in = '0;
               in_run_in = 1'b0;
               run_start_in = '0;
               best_valid_in = 1'b0;
            end else begin
               cnt_in = cnt_new;
               in_run_in = mid_in_run;
               run_start_in = mid_start;
               best_valid_in = mid_valid;
               best_left_in = mid_left;
               best_right_in = mid_right;
               best_span_in = mid_span;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         in_run_ff <= 1'b0;
         run_start_ff <= '0;
         best_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         in_run_ff <= in_run_in;
         run_start_ff <= run_start_in;
         best_valid_ff <= best_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_left_ff <= best_left_in;
      best_right_ff <= best_right_in;
      best_span_ff <= best_span_in;
      s3_ff <= s3_in;
      if (adv && s2_valid_ff) begin
         prev_bright_ff <= rd_ff.bright;
      end
   end

   // frame stage: narrowest arc run, result on frame end
   logic frame_started_ff, frame_started_in;
   angle_type frame_left_ff, frame_left_in;
   angle_type frame_right_ff, frame_right_in;
   span_type frame_span_ff, frame_span_in;
   logic frame_take, out_empty;
   angle_type sel_left, sel_right;
   logic s3_fire;

   assign s3_fire = adv && s3_valid_ff;

   always_comb begin
      frame_take = !frame_started_ff || (s3_ff.span < frame_span_ff);
      sel_left = frame_take ? s3_ff.left : frame_left_ff;
      sel_right = frame_take ? s3_ff.right : frame_right_ff;
      out_empty = (sel_left == rlim_ff) && (sel_right == rlim_ff);

      frame_started_in = frame_started_ff;
      frame_left_in = frame_left_ff;
      frame_right_in = frame_right_ff;
      frame_span_in = frame_span_ff;
      rsp_data_in = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s3_fire) begin
         if (s3_ff.frame_done) begin
            frame_started_in = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_data_in = out_empty ? '0 : {sel_right, sel_left};
            rsp_empty_in = out_empty;
         end else begin
            frame_started_in = 1'b1;
            frame_left_in = sel_left;
            frame_right_in = sel_right;
            frame_span_in = frame_take ? s3_ff.span : frame_span_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_started_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_started_ff <= frame_started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_left_ff <= frame_left_in;
      frame_right_ff <= frame_right_in;
      frame_span_ff <= frame_span_in;
      rsp_data_ff <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_empty_ff;

   // checks
   `ARCFAN_ASSERT_NOW(a_count_bound, 1'b1, cnt_ff <= FILL_FULL, "bright count beyond window")
   `ARCFAN_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FILL_FULL, "fill count beyond window")
   `ARCFAN_ASSERT_NEXT(a_arc_restart, req_acc && req_end, (wp_ff == '0) && (fill_ff == '0),
      "window not restarted after arc end")
   `ARCFAN_ASSERT_NEXT(a_result_loaded, s3_fire && s3_ff.frame_done, rsp_valid_ff,
      "frame result lost")

endmodule

`default_nettype wire

### test/tb_arc_run_fan_edge_detector_top.sv
// self-checking testbench of the arc run fan edge detector: directed samples against table
// rows, then random frames under several register settings against a cycle-free predictor
// depends on arcfan_pkg and arc_run_fan_edge_detector_top

module tb_arc_run_fan_edge_detector_top;
   import arcfan_pkg::*;

   localparam int WIN = 20;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 400;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASE_ITEMS = 380;
   localparam int PHASE_FRAMES = 4;

   // one sample and one frame result, as the predictor sees them
   typedef struct packed {
      pixel_type pix;
      angle_type ang;
      logic arc_end;
      logic frame_end;
   } sample_type;

   typedef struct packed {
      angle_type left;
      angle_type right;
      logic empty;
   } fan_edges_type;

   // directed stimulus row: count samples with angle stepping, ends on the last one
   typedef struct packed {
      int pixel;
      int angle;
      int step;
      int count;
      bit arc_end;
      bit frame_end;
      bit typed;
      int exp_left;
      int exp_right;
      bit exp_empty;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;   // pixel [7:0], angle [23:8]
   logic req_tuser = 1'b0;        // arc_end
   logic req_tlast = 1'b0;        // frame_end
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // left_angle [15:0], right_angle [31:16]
   logic rsp_tuser;               // frame_empty
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   arc_run_fan_edge_detector_top #(.WINDOW(WIN)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   // predictor state: registers, window, arc and frame bests
   int cfg_threshold;
   int cfg_limit;
   bit hist_bright [WIN];
   int hist_angle [WIN];
   int lit_count;
   int filled;
   int wr_idx;
   bit run_open;
   int open_left;
   bit best_valid;
   int best_l;
   int best_r;
   int frm_l;
   int frm_r;
   bit frm_started;

   fan_edges_type pending_edges [$];
   int mismatches = 0;
   int edges_seen = 0;
   int items_sent = 0;
   int cycles = 0;
   int burst_left = 0;
   fan_edges_type got_edges;
   fan_edges_type want_edges;
   dir_row_type dir_rows [0:5];

   initial begin
      forever #5 clock = ~clock;
   end

   // run timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // arc state back to empty, as after an arc end
   function automatic void clear_arc();
      for (int i = 0; i < WIN; i++) begin
         hist_bright[i] = 1'b0;
         hist_angle[i] = 0;
      end
      lit_count = 0;
      filled = 0;
      wr_idx = 0;
      run_open = 1'b0;
      open_left = 0;
      best_valid = 1'b0;
      best_l = cfg_limit;
      best_r = cfg_limit;
   endfunction

   // keep the first widest run of the arc
   function automatic void offer_arc_run(int l, int r);
      if (!best_valid || (r - l) > (best_r - best_l)) begin
         best_l = l;
         best_r = r;
         best_valid = 1'b1;
      end
   endfunction

   // queue an expected frame result at the tail
   function automatic void expect_edges(input fan_edges_type e);
      pending_edges = {pending_edges, e};
   endfunction

   // advance the model by one sample, returns 1 with the frame edges on a frame end
   function automatic bit predict_fan_edges(input sample_type s, output fan_edges_type res);
      bit lit;
      int l;
      int r;
      lit = (int'(s.pix) >= cfg_threshold);
      res = '0;
      if (filled >= WIN) lit_count -= int'(hist_bright[wr_idx]);
      else filled++;
      hist_bright[wr_idx] = lit;
      hist_angle[wr_idx] = int'(s.ang);
      lit_count += int'(lit);
      wr_idx = (wr_idx + 1) % WIN;
      // window decision, exactly half opens a closed state and closes an open one
      if (filled >= WIN) begin
         if (!run_open && 2 * lit_count >= WIN) begin
            open_left = hist_angle[wr_idx];
            run_open = 1'b1;
         end else if (run_open && 2 * lit_count <= WIN) begin
            offer_arc_run(open_left, int'(s.ang));
            run_open = 1'b0;
         end
      end
      // arc close, narrowest arc best wins the frame
      if (s.arc_end || s.frame_end) begin
         if (run_open) offer_arc_run(open_left, cfg_limit);
         else offer_arc_run(cfg_limit, cfg_limit);
         if (!frm_started || (best_r - best_l) < (frm_r - frm_l)) begin
            frm_l = best_l;
            frm_r = best_r;
         end
         frm_started = 1'b1;
         clear_arc();
      end
      if (!s.frame_end) return 1'b0;
      l = frm_l;
      r = frm_r;
      res.empty = 1'b0;
      if (l == cfg_limit && r == cfg_limit) begin
         l = 0;
         r = 0;
         res.empty = 1'b1;
      end
      res.left = angle_type'(l);
      res.right = angle_type'(r);
      frm_l = 0;
      frm_r = 0;
      frm_started = 1'b0;
      return 1'b1;
   endfunction

   // pixel on the requested side of the threshold, often right at the boundary
   function automatic pixel_type pick_pixel(bit lit);
      if (lit || cfg_threshold == 0) begin
         if ($urandom_range(0, 7) == 0) return pixel_type'(cfg_threshold);
         return pixel_type'($urandom_range(cfg_threshold, 255));
      end
      if ($urandom_range(0, 7) == 0) return pixel_type'(cfg_threshold - 1);
      return pixel_type'($urandom_range(0, cfg_threshold - 1));
   endfunction

   // one sample transaction with burst gaps, prediction at acceptance
   task automatic send_sample(input sample_type s, input bit typed,
                              input fan_edges_type typed_res);
      int gap;
      bit has;
      fan_edges_type res;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 48);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {s.ang, s.pix};
      req_tuser <= s.arc_end;
      req_tlast <= s.frame_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      has = predict_fan_edges(s, res);
      if (typed) begin
         if (s.frame_end) expect_edges(typed_res);
      end else if (has) begin
         expect_edges(res);
      end
   endtask

   // register write, the caller lowers the enable after its last write
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      if (addr == CSR_PIXEL_THRESHOLD) cfg_threshold = int'(data[PIXEL_W-1:0]);
      else cfg_limit = int'($signed(data));
   endtask

   task automatic set_config(input int thr, input int lim);
      write_reg(CSR_PIXEL_THRESHOLD, CSR_DATA_W'(thr));
      write_reg(CSR_RIGHT_LIMIT, CSR_DATA_W'(lim));
      csr_we <= 1'b0;
   endtask

   // wait for all results, then let the pipeline drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one arc: noise, short, or a well-formed arc with bright and dark stretches
   task automatic send_arc(input bit closes_frame);
      int kind;
      int len;
      int ang;
      int step;
      int run_left;
      bit lit;
      sample_type s;
      kind = $urandom_range(0, 9);
      if (kind == 0) len = $urandom_range(1, 30);
      else if (kind == 1) len = $urandom_range(1, WIN - 1);
      else len = $urandom_range(WIN, WIN + 40);
      ang = $urandom_range(0, 34000) - 18000;
      step = $urandom_range(1, 60);
      if ($urandom_range(0, 15) == 0) step = -step;
      lit = ($urandom_range(0, 1) == 1);
      run_left = $urandom_range(1, 25);
      for (int i = 0; i < len; i++) begin
         if (run_left == 0) begin
            lit = !lit;
            run_left = $urandom_range(1, 25);
         end
         run_left--;
         if (kind == 0) begin
            s.pix = pixel_type'($urandom_range(0, 255));
            s.ang = angle_type'($urandom_range(0, 65535));
         end else begin
            s.pix = pick_pixel(lit);
            s.ang = angle_type'(ang);
            ang += step;
         end
         s.arc_end = 1'b0;
         s.frame_end = 1'b0;
         if (i == len - 1) begin
            if (closes_frame) begin
               s.frame_end = 1'b1;
               s.arc_end = ($urandom_range(0, 1) == 1);
            end else begin
               s.arc_end = 1'b1;
            end
         end else if (kind == 0) begin
            // stray ends inside noise
            s.arc_end = ($urandom_range(0, 63) == 0);
            s.frame_end = ($urandom_range(0, 127) == 0);
         end
         send_sample(s, 1'b0, '0);
      end
   endtask

   // random frames until both the item and frame goals are met
   task automatic run_frames();
      int start;
      int frames;
      int n_arcs;
      start = items_sent;
      frames = 0;
      while (items_sent - start < PHASE_ITEMS || frames < PHASE_FRAMES) begin
         n_arcs = $urandom_range(1, 4);
         for (int a = 0; a < n_arcs; a++) send_arc(a == n_arcs - 1);
         frames++;
      end
   endtask

   // result receiver: changing stall patterns and one long hold-off
   initial begin : rsp_side
      logic [7:0] ready_mask;
      int mode_left;
      int bit_idx;
      bit held;
      ready_mask = 8'hFF;
      mode_left = 0;
      bit_idx = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && edges_seen >= 5) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else begin
            if (mode_left == 0) begin
               case ($urandom_range(0, 2))
                  0: ready_mask = 8'hFF;
                  1: ready_mask = 8'($urandom_range(1, 255));
                  default: ready_mask = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
               endcase
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            rsp_tready <= ready_mask[bit_idx];
            bit_idx = (bit_idx + 1) % 8;
         end
      end
   end

   // result checker against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_edges.left = rsp_tdata[15:0];
         got_edges.right = rsp_tdata[31:16];
         got_edges.empty = rsp_tuser;
         edges_seen++;
         if (pending_edges.size() == 0) begin
            $error("unexpected result: left_angle %0d right_angle %0d frame_empty %0d",
                   got_edges.left, got_edges.right, got_edges.empty);
            mismatches++;
         end else begin
            want_edges = pending_edges.pop_front();
            if (got_edges.left !== want_edges.left) begin
               $error("left_angle: expected %0d, actual %0d", want_edges.left, got_edges.left);
               mismatches++;
            end
            if (got_edges.right !== want_edges.right) begin
               $error("right_angle: expected %0d, actual %0d", want_edges.right, got_edges.right);
               mismatches++;
            end
            if (got_edges.empty !== want_edges.empty) begin
               $error("frame_empty: expected %0d, actual %0d", want_edges.empty, got_edges.empty);
               mismatches++;
            end
         end
      end
   end

   // main sequence
   initial begin
      sample_type s;
      fan_edges_type typed_res;
      cfg_threshold = THRESHOLD_RESET;
      cfg_limit = $signed(RIGHT_LIMIT_RESET);
      clear_arc();
      frm_l = 0;
      frm_r = 0;
      frm_started = 1'b0;

      // pixel, angle, step, count, arc_end, frame_end, typed, left, right, empty
      dir_rows = '{
         // lone frame end after reset: no run, empty frame
         '{0, 0, 0, 1, 1'b0, 1'b1, 1'b1, 0, 0, 1'b1},
         // both ends at the extremes of pixel and angle
         '{255, 18000, 0, 1, 1'b1, 1'b1, 1'b1, 0, 0, 1'b1},
         // short arc just under threshold, no result
         '{32, -18000, 0, 1, 1'b1, 1'b0, 1'b1, 0, 0, 1'b0},
         // frame end without arc end, pixel exactly at threshold
         '{33, -1, 0, 1, 1'b0, 1'b1, 1'b1, 0, 0, 1'b1},
         // half a window bright then half dark: exactly half opens on the last sample,
         // the run is still open at arc end and closes at the right limit
         '{255, -1000, 100, 10, 1'b0, 1'b0, 1'b1, 0, 0, 1'b0},
         '{0, 0, 100, 10, 1'b1, 1'b1, 1'b1, -1000, 0, 1'b0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (dir_rows[r]) begin
         for (int k = 0; k < dir_rows[r].count; k++) begin
            s.pix = pixel_type'(dir_rows[r].pixel);
            s.ang = angle_type'(dir_rows[r].angle + k * dir_rows[r].step);
            s.arc_end = dir_rows[r].arc_end && (k == dir_rows[r].count - 1);
            s.frame_end = dir_rows[r].frame_end && (k == dir_rows[r].count - 1);
            typed_res.left = angle_type'(dir_rows[r].exp_left);
            typed_res.right = angle_type'(dir_rows[r].exp_right);
            typed_res.empty = dir_rows[r].exp_empty;
            send_sample(s, dir_rows[r].typed, typed_res);
         end
      end
      wait_idle();

      // random part under several register settings, extremes first
      set_config(0, -18000);
      run_frames();
      wait_idle();
      set_config(255, 18000);
      run_frames();
      wait_idle();
      set_config($urandom_range(1, 254), $urandom_range(0, 36000) - 18000);
      run_frames();
      wait_idle();
      set_config(100, 0);
      run_frames();
      wait_idle();
      set_config(THRESHOLD_RESET, $urandom_range(0, 36000) - 18000);
      run_frames();
      wait_idle();

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/arcfan_pkg.sv
hdl/arc_run_fan_edge_detector_top.sv
test/tb_arc_run_fan_edge_detector_top.sv
